>>> rtl/idqr_pkg.sv
`default_nettype none
package idqr_pkg;

   // Fixed field widths of the request and response items
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 5;
   localparam int SIZE_W   = 6;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 48;   // value + index + new_size, padded to bytes

   // Defaults for the top-level parameters
   localparam int DEPTH_DEFAULT      = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Position width on the cell command bus, covers positions up to 127
   localparam int POS_W = 7;

   // Request actions
   typedef logic [ACTION_W-1:0] action_type;
   localparam action_type ACT_ADD_BACK   = 3'd0;
   localparam action_type ACT_PUSH_FRONT = 3'd1;
   localparam action_type ACT_DROP_FRONT = 3'd2;
   localparam action_type ACT_POP_BACK   = 3'd3;
   localparam action_type ACT_RESIZE     = 3'd4;
   localparam action_type ACT_READ       = 3'd5;
   localparam action_type ACT_DUMP       = 3'd6;
   localparam action_type ACT_WRITE      = 3'd7;

   // Response status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_DATA  = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

   // Commands broadcast to the row of cells
   typedef logic [2:0] cell_code_type;
   localparam cell_code_type CMD_NONE = 3'd0;
   localparam cell_code_type CMD_SHL  = 3'd1;   // take right neighbor (pop front)
   localparam cell_code_type CMD_SHR  = 3'd2;   // take left neighbor (push front)
   localparam cell_code_type CMD_LOAD = 3'd3;   // load write data at pos
   localparam cell_code_type CMD_TRIM = 3'd4;   // invalidate cells at or past pos

   typedef struct packed {
      cell_code_type    code;
      logic [POS_W-1:0] pos;
   } cell_cmd_type;

endpackage
`default_nettype wire

>>> rtl/idqr_cell.sv
`default_nettype none
module idqr_cell #(
   parameter int CELL_IDX   = 0,
   parameter int DATA_WIDTH = idqr_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire idqr_pkg::cell_cmd_type cmd,
   input  wire signed [DATA_WIDTH-1:0] wr_data,
   input  wire signed [DATA_WIDTH-1:0] left_data,
   input  wire                         left_valid,
   input  wire signed [DATA_WIDTH-1:0] right_data,
   input  wire                         right_valid,
   output logic signed [DATA_WIDTH-1:0] data,
   output logic                        valid
);

   localparam logic [idqr_pkg::POS_W-1:0] MY_POS = idqr_pkg::POS_W'(CELL_IDX);

   logic signed [DATA_WIDTH-1:0] data_ff, data_in;
   logic                         valid_ff, valid_in;

   // Next entry from the broadcast command
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      unique case (cmd.code)
         idqr_pkg::CMD_NONE: begin
         end
         idqr_pkg::CMD_SHL: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         idqr_pkg::CMD_SHR: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         idqr_pkg::CMD_LOAD: begin
            if (cmd.pos == MY_POS) begin
               data_in  = wr_data;
               valid_in = 1'b1;
            end
         end
         idqr_pkg::CMD_TRIM: begin
            if (MY_POS >= cmd.pos) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

>>> rtl/indexed_deque_with_resize_top.sv
`default_nettype none
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tuser=action, tdata=value,index,new_size
// rsp      out        rsp_tvalid/rsp_tready   tuser=status, tdata=data, tlast=last
//
// Elements sit in a row of DEPTH cells, cell i holding position i from the front.
// Push, pop, resize, read and write need no busy state. A dump sends one live element
// per cycle while rsp is not stalled, set by the single read port on the cell row.
// Response items come from one output register; a stalled rsp side holds req off.
// Reset (synchronous) empties the deque and clears all valid marks.
module indexed_deque_with_resize_top #(
   parameter int DEPTH      = idqr_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = idqr_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [idqr_pkg::REQ_DATA_W-1:0]     req_tdata,  // value, index, new_size, pad
   input  wire [idqr_pkg::ACTION_W-1:0]       req_tuser,  // action
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [idqr_pkg::VALUE_W-1:0]       rsp_tdata,  // data
   output logic [idqr_pkg::STATUS_W-1:0]      rsp_tuser,  // status
   output logic                               rsp_tlast
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > idqr_pkg::SIZE_W) ? CNT_W : idqr_pkg::SIZE_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CMP_W-1:0] CMP_FULL = CMP_W'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   // Request fields
   logic signed [idqr_pkg::VALUE_W-1:0] req_value;
   logic [idqr_pkg::INDEX_W-1:0]        req_index;
   logic [idqr_pkg::SIZE_W-1:0]         req_new_size;
   idqr_pkg::action_type                req_action;

   assign req_value    = req_tdata[idqr_pkg::VALUE_W-1:0];
   assign req_index    = req_tdata[idqr_pkg::VALUE_W +: idqr_pkg::INDEX_W];
   assign req_new_size = req_tdata[idqr_pkg::VALUE_W + idqr_pkg::INDEX_W +: idqr_pkg::SIZE_W];
   assign req_action   = req_tuser;

   // Control and output registers
   logic                         state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [idqr_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   idqr_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Cell row
   idqr_pkg::cell_cmd_type       cell_cmd;
   logic signed [DATA_WIDTH-1:0] wr_data;
   logic signed [DATA_WIDTH-1:0] cell_data  [DEPTH];
   logic                         cell_valid [DEPTH];
   logic signed [DATA_WIDTH-1:0] lft_data   [DEPTH];
   logic                         lft_valid  [DEPTH];
   logic signed [DATA_WIDTH-1:0] rgt_data   [DEPTH];
   logic                         rgt_valid  [DEPTH];

   assign wr_data = DATA_WIDTH'(req_value);

   // Neighbor links; new front element enters at cell 0, an empty slot at the end
   always_comb begin
      lft_data[0]        = wr_data;
      lft_valid[0]       = 1'b1;
      rgt_data[DEPTH-1]  = '0;
      rgt_valid[DEPTH-1] = 1'b0;
      for (int i = 1; i < DEPTH; i++) begin
         lft_data[i]    = cell_data[i-1];
         lft_valid[i]   = cell_valid[i-1];
         rgt_data[i-1]  = cell_data[i];
         rgt_valid[i-1] = cell_valid[i];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      idqr_cell #(
         .CELL_IDX   (g),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .wr_data     (wr_data),
         .left_data   (lft_data[g]),
         .left_valid  (lft_valid[g]),
         .right_data  (rgt_data[g]),
         .right_valid (rgt_valid[g]),
         .data        (cell_data[g]),
         .valid       (cell_valid[g])
      );
   end

   // Single read port: request index when idle, dump position otherwise
   logic [IDX_W-1:0]             rd_addr;
   logic [idqr_pkg::VALUE_W-1:0] rd_data;

   assign rd_addr = (state_ff == ST_DUMP) ? pos_ff : IDX_W'(req_index);
   assign rd_data = cell_valid[rd_addr] ? idqr_pkg::VALUE_W'(cell_data[rd_addr]) : '0;

   logic out_free, accept;
   logic [CMP_W-1:0] idx_cmp, cnt_cmp, size_cmp;
   logic [CNT_W-1:0] size_sat;
   logic             idx_ok, full, empty;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign idx_cmp  = CMP_W'(req_index);
   assign cnt_cmp  = CMP_W'(count_ff);
   assign size_cmp = CMP_W'(req_new_size);
   assign idx_ok   = idx_cmp < cnt_cmp;
   assign full     = count_ff == CNT_FULL;
   assign empty    = count_ff == '0;
   assign size_sat = (size_cmp > CMP_FULL) ? CNT_FULL : CNT_W'(size_cmp);

   // Sequencer: one action per transfer, dump walks the row
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cell_cmd.code = idqr_pkg::CMD_NONE;
      cell_cmd.pos  = '0;

      if (state_ff == ST_DUMP) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = rd_data;
            rsp_status_in = idqr_pkg::ST_DATA;
            rsp_last_in   = CNT_W'(pos_ff) == count_ff - 1'b1;
            pos_in        = pos_ff + 1'b1;
            if (rsp_last_in) begin
               state_in = ST_IDLE;
            end
         end
      end else if (accept) begin
         rsp_data_in   = '0;
         rsp_last_in   = 1'b1;
         unique case (req_action)
            idqr_pkg::ACT_ADD_BACK, idqr_pkg::ACT_PUSH_FRONT: begin
               if (full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = idqr_pkg::ST_FULL;
               end else begin
                  cell_cmd.code = (req_action == idqr_pkg::ACT_ADD_BACK) ?
                                  idqr_pkg::CMD_LOAD : idqr_pkg::CMD_SHR;
                  cell_cmd.pos  = idqr_pkg::POS_W'(count_ff);
                  count_in      = count_ff + 1'b1;
               end
            end
            idqr_pkg::ACT_DROP_FRONT: begin
               if (!empty) begin
                  cell_cmd.code = idqr_pkg::CMD_SHL;
                  count_in      = count_ff - 1'b1;
               end
            end
            idqr_pkg::ACT_POP_BACK: begin
               if (!empty) begin
                  cell_cmd.code = idqr_pkg::CMD_TRIM;
                  cell_cmd.pos  = idqr_pkg::POS_W'(count_ff - 1'b1);
                  count_in      = count_ff - 1'b1;
               end
            end
            idqr_pkg::ACT_RESIZE: begin
               // growing leaves the new cells invalid, so they read as zero
               cell_cmd.code = idqr_pkg::CMD_TRIM;
               cell_cmd.pos  = idqr_pkg::POS_W'(size_sat);
               count_in      = size_sat;
            end
            idqr_pkg::ACT_READ: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = idx_ok ? idqr_pkg::ST_DATA : idqr_pkg::ST_RANGE;
               rsp_data_in   = idx_ok ? rd_data : '0;
            end
            idqr_pkg::ACT_DUMP: begin
               if (empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = idqr_pkg::ST_EMPTY;
               end else begin
                  state_in = ST_DUMP;
                  pos_in   = '0;
               end
            end
            idqr_pkg::ACT_WRITE: begin
               if (idx_ok) begin
                  cell_cmd.code = idqr_pkg::CMD_LOAD;
                  cell_cmd.pos  = idqr_pkg::POS_W'(req_index);
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = idqr_pkg::ST_RANGE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;

   localparam int DEPTH       = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_REPORTS = 10;
   localparam int EXP_DEPTH   = 256;

   // one response item as the checker sees it
   typedef struct packed {
      logic [idqr_pkg::VALUE_W-1:0] data;
      idqr_pkg::status_type         status;
      logic                         last;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [idqr_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // value, index, new_size, pad
   idqr_pkg::action_type            req_tuser  = idqr_pkg::ACT_ADD_BACK;   // action
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [idqr_pkg::VALUE_W-1:0]    rsp_tdata;   // data
   idqr_pkg::status_type            rsp_tuser;   // status
   logic                            rsp_tlast;

   // predictor copy of the deque
   logic [idqr_pkg::VALUE_W-1:0] elem_mem [DEPTH];
   logic                         elem_ok  [DEPTH];
   logic [4:0]                   head_ptr   = '0;
   int                           live_count = 0;

   // expected responses, written by the predictor, read by the checker
   rsp_item_type exp_buf [EXP_DEPTH];
   int           exp_wr = 0;
   int           exp_rd = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;

   indexed_deque_with_resize_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) elem_ok[i] = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_expected(input logic [idqr_pkg::VALUE_W-1:0] data,
                                 input idqr_pkg::status_type status, input logic last);
      rsp_item_type item;
      item.data   = data;
      item.status = status;
      item.last   = last;
      exp_buf[exp_wr % EXP_DEPTH] = item;
      exp_wr++;
   endtask

   function automatic logic [idqr_pkg::VALUE_W-1:0] element_at(input int pos);
      logic [4:0] slot;
      slot = head_ptr + 5'(pos);
      return elem_ok[slot] ? elem_mem[slot] : '0;
   endfunction

   // apply one request to the predictor and queue the responses it causes
   task automatic predict_deque(input idqr_pkg::action_type act,
                                input logic [idqr_pkg::VALUE_W-1:0] val,
                                input logic [4:0] idx, input logic [5:0] nsz);
      logic [4:0] slot;
      int target;
      case (act)
         idqr_pkg::ACT_ADD_BACK, idqr_pkg::ACT_PUSH_FRONT: begin
            if (live_count >= DEPTH) begin
               queue_expected('0, idqr_pkg::ST_FULL, 1'b1);
            end else begin
               if (act == idqr_pkg::ACT_ADD_BACK) begin
                  slot = head_ptr + 5'(live_count);
               end else begin
                  head_ptr = head_ptr - 5'd1;
                  slot = head_ptr;
               end
               elem_mem[slot] = val;
               elem_ok[slot]  = 1'b1;
               live_count++;
            end
         end
         idqr_pkg::ACT_DROP_FRONT: begin
            if (live_count > 0) begin
               elem_ok[head_ptr] = 1'b0;
               head_ptr = head_ptr + 5'd1;
               live_count--;
            end
         end
         idqr_pkg::ACT_POP_BACK: begin
            if (live_count > 0) begin
               elem_ok[head_ptr + 5'(live_count - 1)] = 1'b0;
               live_count--;
            end
         end
         idqr_pkg::ACT_RESIZE: begin
            target = (int'(nsz) > DEPTH) ? DEPTH : int'(nsz);
            // shrinking drops valid marks, growing leaves new slots reading zero
            while (live_count > target) begin
               elem_ok[head_ptr + 5'(live_count - 1)] = 1'b0;
               live_count--;
            end
            live_count = target;
         end
         idqr_pkg::ACT_READ: begin
            if (int'(idx) >= live_count) queue_expected('0, idqr_pkg::ST_RANGE, 1'b1);
            else queue_expected(element_at(int'(idx)), idqr_pkg::ST_DATA, 1'b1);
         end
         idqr_pkg::ACT_DUMP: begin
            if (live_count == 0) begin
               queue_expected('0, idqr_pkg::ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < live_count; i++)
                  queue_expected(element_at(i), idqr_pkg::ST_DATA, i == live_count - 1);
            end
         end
         default: begin
            if (int'(idx) >= live_count) begin
               queue_expected('0, idqr_pkg::ST_RANGE, 1'b1);
            end else begin
               slot = head_ptr + idx;
               elem_mem[slot] = val;
               elem_ok[slot]  = 1'b1;
            end
         end
      endcase
   endtask

   // one request transfer, with random idle cycles ahead of it
   task automatic send_request(input idqr_pkg::action_type act,
                               input logic [idqr_pkg::VALUE_W-1:0] val,
                               input logic [4:0] idx, input logic [5:0] nsz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'b0, nsz, idx, val};
      predict_deque(act, val, idx, nsz);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic log_mismatch(input string what, input rsp_item_type want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch (%s) at cycle %0d: exp data=%h status=%0d last=%0d,",
                  what, cycle_count, want.data, want.status, want.last,
                  " got data=%h status=%0d last=%0d", rsp_tdata, rsp_tuser, rsp_tlast);
   endtask

   // response side: random stalls and the in-order check
   rsp_item_type rsp_want;
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_rd == exp_wr) begin
            log_mismatch("unexpected transfer", '0);
         end else begin
            rsp_want = exp_buf[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_tdata !== rsp_want.data || rsp_tuser !== rsp_want.status ||
                rsp_tlast !== rsp_want.last)
               log_mismatch("field", rsp_want);
         end
      end
   end

   // empty deque: every special case of an empty store
   task automatic test_empty_deque();
      send_request(idqr_pkg::ACT_DUMP, '0, '0, '0);
      send_request(idqr_pkg::ACT_DROP_FRONT, '0, '0, '0);
      send_request(idqr_pkg::ACT_POP_BACK, '0, '0, '0);
      send_request(idqr_pkg::ACT_READ, '0, 5'd0, '0);
      send_request(idqr_pkg::ACT_WRITE, 32'h1234_5678, 5'd0, '0);
   endtask

   // value extremes through both push ends, reads, writes, a dump and pops
   task automatic test_value_extremes();
      send_request(idqr_pkg::ACT_ADD_BACK, 32'h7fff_ffff, '0, '0);
      send_request(idqr_pkg::ACT_PUSH_FRONT, 32'h8000_0000, '0, '0);
      send_request(idqr_pkg::ACT_ADD_BACK, 32'h0000_0000, '0, '0);
      send_request(idqr_pkg::ACT_PUSH_FRONT, 32'hffff_ffff, '0, '0);
      send_request(idqr_pkg::ACT_READ, '0, 5'd0, '0);
      send_request(idqr_pkg::ACT_READ, '0, 5'd3, '0);
      send_request(idqr_pkg::ACT_READ, '0, 5'd31, '0);
      send_request(idqr_pkg::ACT_WRITE, 32'hdead_beef, 5'd3, '0);
      send_request(idqr_pkg::ACT_DUMP, '0, '0, '0);
      send_request(idqr_pkg::ACT_DROP_FRONT, '0, '0, '0);
      send_request(idqr_pkg::ACT_POP_BACK, '0, '0, '0);
   endtask

   // saturating grow, reads and dumps, full pushes, a write, shrink to nothing and regrow
   task automatic test_full_and_resize();
      send_request(idqr_pkg::ACT_RESIZE, '0, '0, 6'd63);
      send_request(idqr_pkg::ACT_READ, '0, 5'd31, '0);
      send_request(idqr_pkg::ACT_DUMP, '0, '0, '0);
      send_request(idqr_pkg::ACT_ADD_BACK, 32'h0bad_f00d, '0, '0);
      send_request(idqr_pkg::ACT_PUSH_FRONT, 32'h0bad_f00d, '0, '0);
      send_request(idqr_pkg::ACT_WRITE, 32'h5555_aaaa, 5'd31, '0);
      send_request(idqr_pkg::ACT_RESIZE, '0, '0, 6'd0);
      send_request(idqr_pkg::ACT_DUMP, '0, '0, '0);
      send_request(idqr_pkg::ACT_RESIZE, '0, '0, 6'd32);
   endtask

   // mostly legal traffic with random content, some out-of-range noise
   task automatic test_random(input int n_items, input int idle, input int stall);
      idqr_pkg::action_type act;
      int pick;
      logic [idqr_pkg::VALUE_W-1:0] val;
      logic [4:0] idx;
      logic [5:0] nsz;
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (n_items) begin
         pick = $urandom_range(99);
         if (pick < 22)      act = idqr_pkg::ACT_ADD_BACK;
         else if (pick < 40) act = idqr_pkg::ACT_PUSH_FRONT;
         else if (pick < 50) act = idqr_pkg::ACT_DROP_FRONT;
         else if (pick < 60) act = idqr_pkg::ACT_POP_BACK;
         else if (pick < 66) act = idqr_pkg::ACT_RESIZE;
         else if (pick < 78) act = idqr_pkg::ACT_READ;
         else if (pick < 92) act = idqr_pkg::ACT_WRITE;
         else                act = idqr_pkg::ACT_DUMP;
         case ($urandom_range(7))
            0:       val = 32'h7fff_ffff;
            1:       val = 32'h8000_0000;
            2:       val = ($urandom_range(1) != 0) ? 32'hffff_ffff : 32'h0;
            default: val = $urandom;
         endcase
         if (live_count > 0 && $urandom_range(3) != 0)
            idx = 5'($urandom_range(live_count - 1));
         else
            idx = 5'($urandom_range(31));
         nsz = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
         send_request(act, val, idx, nsz);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_deque();
      test_value_extremes();
      test_full_and_resize();
      test_random(72, 0, 0);
      test_random(72, 50, 0);
      test_random(72, 0, 50);
      test_random(72, 12, 12);

      // drain
      req_tvalid <= 1'b0;
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
rtl/idqr_pkg.sv
rtl/idqr_cell.sv
rtl/indexed_deque_with_resize_top.sv
tb/tb_top.sv
